[design/quantized_conv_mac_requantize_top_assert.svh]
// Assertion macros shared by the quantized convolution MAC blocks.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef QUANTIZED_CONV_MAC_REQUANTIZE_TOP_ASSERT_SVH
`define QUANTIZED_CONV_MAC_REQUANTIZE_TOP_ASSERT_SVH

`ifndef SYNTH
`define QCMR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("qcmr assertion failed");
`define QCMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qcmr next-cycle assertion failed");
`else
`define QCMR_ASSERT(lbl, prop)
`define QCMR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/qcmr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the quantized convolution MAC.
// No dependencies; imported by every module of the block.
package qcmr_pkg;

    localparam int CODE_W     = 9;
    localparam int DIFF_W     = 10;
    localparam int TERM_W     = 20;
    localparam int BIAS_W     = 32;
    localparam int MANT_W     = 31;
    localparam int SHIFT_W    = 6;
    localparam int ACC_W      = 36;
    localparam int MAG_W      = 32;
    localparam int PROD_W     = MAG_W + MANT_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Accumulator clip bound applied before the bias.
    localparam longint ACC_LIM = 64'sd17179869184;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_ZP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIGNED = 2'd2;

    typedef struct packed {
        logic signed [BIAS_W-1:0] bias;
        logic [MANT_W-1:0]        mant;
        logic [SHIFT_W-1:0]       shift;
    } t_scale;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[design/qcmr_front.sv]
`timescale 1ns / 1ps
// Front end: accepts terms and keeps the saturating running sum.
// Uses qcmr_pkg; pushes finished sums into qcmr_queue.
module qcmr_front #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [qcmr_pkg::CODE_W-1:0]    i_act_code,
    input  logic signed [qcmr_pkg::CODE_W-1:0]    i_wt_code,
    input  logic signed [qcmr_pkg::CODE_W-1:0]    i_wt_zero_point,
    input  logic                                  i_in_window,
    input  logic signed [qcmr_pkg::BIAS_W-1:0]    i_bias_value,
    input  logic [qcmr_pkg::MANT_W-1:0]           i_scale_mantissa,
    input  logic [qcmr_pkg::SHIFT_W-1:0]          i_scale_shift,
    input  logic                                  i_last_term,
    input  logic signed [qcmr_pkg::CODE_W-1:0]    i_in_zp,
    input  qcmr_pkg::t_q_stat                     i_q_stat,
    output logic                                  o_push,
    output logic signed [SUM_WIDTH-1:0]           o_push_sum,
    output qcmr_pkg::t_scale                      o_push_scale
);
    import qcmr_pkg::*;

    logic signed [SUM_WIDTH-1:0] r_sum, n_sum;
    logic signed [DIFF_W-1:0]    w_a, w_b;
    logic signed [TERM_W-1:0]    w_term;
    logic signed [SUM_WIDTH:0]   w_wide;
    logic signed [SUM_WIDTH-1:0] w_sat, w_new;
    logic                        w_accept;

    assign w_a    = DIFF_W'(i_act_code) - DIFF_W'(i_in_zp);
    assign w_b    = DIFF_W'(i_wt_code) - DIFF_W'(i_wt_zero_point);
    assign w_term = w_a * w_b;
    assign w_wide = (SUM_WIDTH+1)'(r_sum) + (SUM_WIDTH+1)'(w_term);

    // The sum sticks at the signed bounds instead of wrapping.
    always_comb begin
        if (w_wide[SUM_WIDTH] != w_wide[SUM_WIDTH-1]) begin
            w_sat = w_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            w_sat = w_wide[SUM_WIDTH-1:0];
        end
        w_new = i_in_window ? w_sat : r_sum;
    end

    assign w_accept = i_valid && !i_q_stat.full;
    assign o_stall  = i_q_stat.full;

    always_comb begin
        n_sum = r_sum;
        if (w_accept) begin
            n_sum = i_last_term ? '0 : w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_push             = w_accept && i_last_term;
    assign o_push_sum         = w_new;
    assign o_push_scale.bias  = i_bias_value;
    assign o_push_scale.mant  = i_scale_mantissa;
    assign o_push_scale.shift = i_scale_shift;

endmodule

[design/qcmr_queue.sv]
`timescale 1ns / 1ps
// Short queue of finished sums between the front and back ends.
// Uses qcmr_pkg and the assertion macro header.
`include "quantized_conv_mac_requantize_top_assert.svh"
module qcmr_queue #(
    parameter int WIDTH = 117
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output qcmr_pkg::t_q_stat o_stat
);
    import qcmr_pkg::*;

    logic [WIDTH-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_push, w_pop;

    assign o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(w_push) - FIFO_CNT_W'(w_pop);
        end
    end

    `QCMR_ASSERT(a_count_bound, r_count <= FIFO_CNT_W'(FIFO_DEPTH))
    `QCMR_ASSERT_NEXT(a_pop_drains, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

[design/qcmr_back.sv]
`timescale 1ns / 1ps
// Back end: bias, range check, fixed-point rescale and output clamp.
// Uses qcmr_pkg and the assertion macro header; fed by qcmr_queue.
`include "quantized_conv_mac_requantize_top_assert.svh"
module qcmr_back #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [SUM_WIDTH-1:0]         i_q_sum,
    input  qcmr_pkg::t_scale                    i_q_scale,
    input  qcmr_pkg::t_q_stat                   i_q_stat,
    output logic                                o_pop,
    input  logic signed [qcmr_pkg::CODE_W-1:0]  i_out_zp,
    input  logic                                i_out_signed,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [qcmr_pkg::CODE_W-1:0]  o_result_code,
    output logic                                o_overflow_flag
);
    import qcmr_pkg::*;

    localparam int CMP_W = (SUM_WIDTH > ACC_W) ? SUM_WIDTH : ACC_W;
    localparam logic signed [CMP_W-1:0] LIM_HI = CMP_W'(ACC_LIM);
    localparam logic signed [CMP_W-1:0] LIM_LO = -CMP_W'(ACC_LIM);
    localparam logic signed [33:0] S_MIN = -34'sd128;
    localparam logic signed [33:0] S_MAX = 34'sd127;
    localparam logic signed [33:0] U_MIN = 34'sd0;
    localparam logic signed [33:0] U_MAX = 34'sd255;

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_out_v;

    // Stage 1: clip and add bias.
    logic signed [CMP_W-1:0] w_sx, w_clip;
    logic signed [ACC_W-1:0] r1_acc;
    logic [MANT_W-1:0]       r1_mant;
    logic [SHIFT_W-1:0]      r1_shift;
    // Stage 2: range check and magnitude.
    logic [ACC_W-32:0]       w_hi_bits;
    logic signed [ACC_W-1:0] w_abs;
    logic                    r2_ovf, r2_neg;
    logic [MAG_W-1:0]        r2_mag;
    logic [MANT_W-1:0]       r2_mant;
    logic [SHIFT_W-1:0]      r2_shift;
    // Stage 3: product.
    logic                    r3_ovf, r3_neg;
    logic [PROD_W-1:0]       r3_prod;
    logic [SHIFT_W-1:0]      r3_shift;
    // Stage 4: rounding shift.
    logic [6:0]              w_s, w_sm1;
    logic [PROD_W-1:0]       w_sh1, w_mask;
    logic                    w_sticky, w_inc;
    logic [MAG_W-1:0]        w_q, w_qc;
    logic                    r4_ovf;
    logic signed [31:0]      r4_y;
    // Output stage.
    logic signed [33:0]      w_y, w_lo, w_hi, w_cl;
    logic signed [CODE_W-1:0] r_out_code;
    logic                    r_out_ovf;

    assign w_en  = !(r_out_v && i_stall);
    assign o_pop = w_en && !i_q_stat.empty;

    always_comb begin
        w_sx = CMP_W'(i_q_sum);
        if (w_sx > LIM_HI) begin
            w_clip = LIM_HI;
        end else if (w_sx < LIM_LO) begin
            w_clip = LIM_LO;
        end else begin
            w_clip = w_sx;
        end
    end

    assign w_hi_bits = r1_acc[ACC_W-1:31];
    assign w_abs     = r1_acc[ACC_W-1] ? -r1_acc : r1_acc;

    // Round half to even: round bit below the kept part, sticky below that.
    always_comb begin
        w_s      = 7'd31 + 7'(r3_shift);
        w_sm1    = w_s - 7'd1;
        w_sh1    = r3_prod >> w_sm1;
        w_mask   = (PROD_W'(1) << w_sm1) - PROD_W'(1);
        w_sticky = |(r3_prod & w_mask);
        w_inc    = w_sh1[0] & (w_sticky | w_sh1[1]);
        w_q      = (w_s >= 7'd63) ? '0 : (w_sh1[MAG_W:1] + MAG_W'(w_inc));
        if (!r3_neg && w_q > 32'h7FFF_FFFF) begin
            w_qc = 32'h7FFF_FFFF;
        end else if (r3_neg && w_q > 32'h8000_0000) begin
            w_qc = 32'h8000_0000;
        end else begin
            w_qc = w_q;
        end
    end

    always_comb begin
        w_y  = 34'(r4_y) + 34'(i_out_zp);
        w_lo = i_out_signed ? S_MIN : U_MIN;
        w_hi = i_out_signed ? S_MAX : U_MAX;
        if (w_y < w_lo) begin
            w_cl = w_lo;
        end else if (w_y > w_hi) begin
            w_cl = w_hi;
        end else begin
            w_cl = w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_acc     <= ACC_W'(w_clip) + ACC_W'($signed(i_q_scale.bias));
            r1_mant    <= i_q_scale.mant;
            r1_shift   <= i_q_scale.shift;
            r2_ovf     <= !((&w_hi_bits) || (~|w_hi_bits));
            r2_neg     <= r1_acc[ACC_W-1];
            r2_mag     <= w_abs[MAG_W-1:0];
            r2_mant    <= r1_mant;
            r2_shift   <= r1_shift;
            r3_ovf     <= r2_ovf;
            r3_neg     <= r2_neg;
            r3_prod    <= PROD_W'(r2_mag) * PROD_W'(r2_mant);
            r3_shift   <= r2_shift;
            r4_ovf     <= r3_ovf;
            r4_y       <= r3_neg ? $signed(32'd0 - w_qc) : $signed(w_qc);
            r_out_ovf  <= r4_ovf;
            r_out_code <= r4_ovf ? '0 : w_cl[CODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v1    <= !i_q_stat.empty;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_out_v <= r_v4;
        end
    end

    assign o_valid         = r_out_v;
    assign o_result_code   = r_out_code;
    assign o_overflow_flag = r_out_ovf;

    `QCMR_ASSERT(a_ovf_zero, (r_out_v && r_out_ovf) |-> (r_out_code == '0))
    `QCMR_ASSERT(a_signed_range, (r_out_v && i_out_signed) |-> (r_out_code[8] == r_out_code[7]))
    `QCMR_ASSERT_NEXT(a_stage_moves, r_v4 && w_en, r_out_v)

endmodule

[design/quantized_conv_mac_requantize_top.sv]
`timescale 1ns / 1ps
// Quantized convolution MAC with requantization, one output element per run.
// Input channel: i_valid / o_stall carry one term word per cycle (activation,
// weight, weight zero point, window bit, bias, scale and last marker). A word
// is taken at a clock edge with i_valid high and o_stall low. Padding words
// (window bit low) add nothing; the word marked last closes the element.
// Output channel: o_valid / i_stall carry one result word per closed element:
// the requantized code and the int32 overflow flag.
// Throughput: one term word per cycle while o_stall is low. The front
// accumulator takes a 10x10 product and a saturating add each cycle;
// closed sums wait in a four-entry queue for the back pipeline (bias,
// range check, 32x31 multiply, rounding shift, zero point and clamp),
// each step registered in turn.
// A stall on a valid output freezes the back pipeline; the front keeps
// summing until the queue holds four closed elements, then raises o_stall.
// Reset (i_rst_n low, synchronous) clears the sum, the queue, the pipeline
// valids and the registers: both zero points 0, unsigned 0..255 output.
// Configuration: i_cfg_we with i_cfg_idx 0 input zero point, 1 output zero
// point, 2 signed output; other indexes are ignored.
module quantized_conv_mac_requantize_top #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [qcmr_pkg::CODE_W-1:0]     i_act_code,
    input  logic signed [qcmr_pkg::CODE_W-1:0]     i_wt_code,
    input  logic signed [qcmr_pkg::CODE_W-1:0]     i_wt_zero_point,
    input  logic                                   i_in_window,
    input  logic signed [qcmr_pkg::BIAS_W-1:0]     i_bias_value,
    input  logic [qcmr_pkg::MANT_W-1:0]            i_scale_mantissa,
    input  logic [qcmr_pkg::SHIFT_W-1:0]           i_scale_shift,
    input  logic                                   i_last_term,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [qcmr_pkg::CODE_W-1:0]     o_result_code,
    output logic                                   o_overflow_flag,
    input  logic                                   i_cfg_we,
    input  logic [qcmr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [qcmr_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import qcmr_pkg::*;

    localparam int Q_W = SUM_WIDTH + $bits(t_scale);

    logic signed [CODE_W-1:0]    r_in_zp, r_out_zp;
    logic                        r_out_signed;
    t_q_stat                     w_q_stat;
    logic                        w_push, w_pop;
    logic signed [SUM_WIDTH-1:0] w_push_sum;
    t_scale                      w_push_scale, w_q_scale;
    logic [Q_W-1:0]              w_q_out;
    logic signed [SUM_WIDTH-1:0] w_q_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_zp      <= '0;
            r_out_zp     <= '0;
            r_out_signed <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_ZP:      r_in_zp      <= $signed(i_cfg_data[CODE_W-1:0]);
                CFG_OUT_ZP:     r_out_zp     <= $signed(i_cfg_data[CODE_W-1:0]);
                CFG_OUT_SIGNED: r_out_signed <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    qcmr_front #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_act_code       (i_act_code),
        .i_wt_code        (i_wt_code),
        .i_wt_zero_point  (i_wt_zero_point),
        .i_in_window      (i_in_window),
        .i_bias_value     (i_bias_value),
        .i_scale_mantissa (i_scale_mantissa),
        .i_scale_shift    (i_scale_shift),
        .i_last_term      (i_last_term),
        .i_in_zp          (r_in_zp),
        .i_q_stat         (w_q_stat),
        .o_push           (w_push),
        .o_push_sum       (w_push_sum),
        .o_push_scale     (w_push_scale)
    );

    qcmr_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_sum, w_push_scale}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_q_stat)
    );

    assign w_q_sum   = $signed(w_q_out[Q_W-1:$bits(t_scale)]);
    assign w_q_scale = w_q_out[$bits(t_scale)-1:0];

    qcmr_back #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_sum         (w_q_sum),
        .i_q_scale       (w_q_scale),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .i_out_zp        (r_out_zp),
        .i_out_signed    (r_out_signed),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_code   (o_result_code),
        .o_overflow_flag (o_overflow_flag)
    );

endmodule

[sim/qcmr_checker.sv]
`timescale 1ns / 1ps
// Result checker for the quantized convolution MAC: watches the term and result
// word channels and the register port, predicts every result word and compares.
// Depends on qcmr_pkg for field widths, the accumulator clip bound and register indexes.
module qcmr_checker #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [qcmr_pkg::CODE_W-1:0]  i_act_code,
    input  logic signed [qcmr_pkg::CODE_W-1:0]  i_wt_code,
    input  logic signed [qcmr_pkg::CODE_W-1:0]  i_wt_zero_point,
    input  logic                                i_in_window,
    input  logic signed [qcmr_pkg::BIAS_W-1:0]  i_bias_value,
    input  logic [qcmr_pkg::MANT_W-1:0]         i_scale_mantissa,
    input  logic [qcmr_pkg::SHIFT_W-1:0]        i_scale_shift,
    input  logic                                i_last_term,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [qcmr_pkg::CODE_W-1:0]  i_result_code,
    input  logic                                i_overflow_flag,
    input  logic                                i_cfg_we,
    input  logic [qcmr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [qcmr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_result_count,
    output int                                  o_overflow_count
);
    import qcmr_pkg::*;

    localparam longint SUM_MAX = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
    localparam longint SUM_MIN = -SUM_MAX - 64'sd1;
    localparam longint S32_HI  = 64'sd2147483647;
    localparam longint S32_LO  = -64'sd2147483648;

    typedef struct packed {
        logic signed [CODE_W-1:0] code;
        logic                     ovf;
    } t_qword;

    t_qword                   expected_words[$];
    longint                   mac_sum     = 0;
    logic signed [CODE_W-1:0] in_zp       = '0;
    logic signed [CODE_W-1:0] out_zp      = '0;
    logic                     out_signed  = 1'b0;
    int                       fail_total  = 0;
    int                       result_total = 0;
    int                       ovf_total   = 0;

    // The running sum saturates at the accumulator bounds instead of wrapping.
    function automatic longint mac_add(input longint sum, input longint term);
        if (term > 0 && sum > SUM_MAX - term) begin
            return SUM_MAX;
        end
        if (term < 0 && sum < SUM_MIN - term) begin
            return SUM_MIN;
        end
        return sum + term;
    endfunction

    function automatic t_qword requantize(input longint sum,
                                          input logic signed [BIAS_W-1:0] bias,
                                          input logic [MANT_W-1:0] mant,
                                          input logic [SHIFT_W-1:0] sh,
                                          input logic signed [CODE_W-1:0] zp,
                                          input logic sgn);
        longint      acc;
        longint      y;
        logic [63:0] mag;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] q;
        int          s;
        t_qword      r;
        acc = sum;
        if (acc > ACC_LIM) begin
            acc = ACC_LIM;
        end
        if (acc < -ACC_LIM) begin
            acc = -ACC_LIM;
        end
        acc = acc + longint'(bias);
        r.code = '0;
        r.ovf  = 1'b0;
        if (acc < S32_LO || acc > S32_HI) begin
            r.ovf = 1'b1;
            return r;
        end
        mag = (acc < 0) ? 64'(-acc) : 64'(acc);
        mag = mag * 64'(mant);
        s   = 31 + int'(sh);
        // The product stays below 2^62, so a shift of 63 or more leaves nothing.
        if (s >= 63) begin
            q = '0;
        end else begin
            rem  = mag & ((64'd1 << s) - 64'd1);
            half = 64'd1 << (s - 1);
            q    = mag >> s;
            if (rem > half || (rem == half && q[0])) begin
                q = q + 64'd1;
            end
        end
        if (acc < 0) begin
            y = (q > 64'd2147483648) ? S32_LO : -longint'(q);
        end else begin
            y = (q > 64'd2147483647) ? S32_HI : longint'(q);
        end
        y = y + longint'(zp);
        if (sgn) begin
            if (y < -128) y = -128;
            if (y > 127)  y = 127;
        end else begin
            if (y < 0)   y = 0;
            if (y > 255) y = 255;
        end
        r.code = CODE_W'(y);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_qword got;
        t_qword want;
        longint term;
        if (!i_rst_n) begin
            mac_sum    = 0;
            in_zp      = '0;
            out_zp     = '0;
            out_signed = 1'b0;
            expected_words.delete();
        end else begin
            // Results are checked before this edge's term word is predicted.
            if (i_out_valid && !i_out_stall) begin
                got.code = i_result_code;
                got.ovf  = i_overflow_flag;
                if (expected_words.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result word: code %0d, overflow %0b",
                             $time, got.code, got.ovf);
                end else begin
                    want = expected_words.pop_front();
                    if (got.code !== want.code) begin
                        fail_total++;
                        $display("%0t: result_code expected %0d, got %0d",
                                 $time, want.code, got.code);
                    end
                    if (got.ovf !== want.ovf) begin
                        fail_total++;
                        $display("%0t: overflow_flag expected %0b, got %0b",
                                 $time, want.ovf, got.ovf);
                    end
                    result_total++;
                    if (want.ovf) begin
                        ovf_total++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_ZP:      in_zp = signed'(i_cfg_data);
                    CFG_OUT_ZP:     out_zp = signed'(i_cfg_data);
                    CFG_OUT_SIGNED: out_signed = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_window) begin
                    term = (longint'(i_act_code) - longint'(in_zp)) *
                           (longint'(i_wt_code) - longint'(i_wt_zero_point));
                    mac_sum = mac_add(mac_sum, term);
                end
                if (i_last_term) begin
                    expected_words.push_back(requantize(mac_sum, i_bias_value,
                                                        i_scale_mantissa, i_scale_shift,
                                                        out_zp, out_signed));
                    mac_sum = 0;
                end
            end
        end
        o_pending        <= expected_words.size();
        o_fail_count     <= fail_total;
        o_result_count   <= result_total;
        o_overflow_count <= ovf_total;
    end

endmodule

[sim/tb_quantized_conv_mac_requantize_top.sv]
`timescale 1ns / 1ps
// Testbench top for the quantized convolution MAC: drives term words, register
// writes and output stalls, and reports the verdict from the checker's count.
// Depends on qcmr_pkg, quantized_conv_mac_requantize_top and qcmr_checker.
module tb_quantized_conv_mac_requantize_top;
    import qcmr_pkg::*;

    localparam int SUM_WIDTH    = 48;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_WORDS  = 230;
    localparam int HOLD_CYCLES  = 400;
    localparam int WATCHDOG_MAX = 5000;
    localparam int QUIET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint MANT_MAX  = 64'h7FFF_FFFF;
    localparam longint MANT_HALF = 64'h4000_0000;

    typedef struct packed {
        logic signed [CODE_W-1:0] act;
        logic signed [CODE_W-1:0] wt;
        logic signed [CODE_W-1:0] wzp;
        logic                     win;
        logic signed [BIAS_W-1:0] bias;
        logic [MANT_W-1:0]        mant;
        logic [SHIFT_W-1:0]       shift;
        logic                     last;
    } t_term_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [CODE_W-1:0]  i_act_code;
    logic signed [CODE_W-1:0]  i_wt_code;
    logic signed [CODE_W-1:0]  i_wt_zero_point;
    logic                      i_in_window;
    logic signed [BIAS_W-1:0]  i_bias_value;
    logic [MANT_W-1:0]         i_scale_mantissa;
    logic [SHIFT_W-1:0]        i_scale_shift;
    logic                      i_last_term;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [CODE_W-1:0]  o_result_code;
    logic                      o_overflow_flag;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int fail_count;
    int pending_results;
    int result_count;
    int overflow_count;

    int rx_stall_pct = 0;
    int hold_ask     = 0;
    int tx_idle_pct  = 0;
    int words_sent   = 0;
    int idle_cycles  = 0;
    logic signed [CODE_W-1:0] cur_in_zp = '0;

    quantized_conv_mac_requantize_top #(
        .SUM_WIDTH(SUM_WIDTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_act_code      (i_act_code),
        .i_wt_code       (i_wt_code),
        .i_wt_zero_point (i_wt_zero_point),
        .i_in_window     (i_in_window),
        .i_bias_value    (i_bias_value),
        .i_scale_mantissa(i_scale_mantissa),
        .i_scale_shift   (i_scale_shift),
        .i_last_term     (i_last_term),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_code   (o_result_code),
        .o_overflow_flag (o_overflow_flag),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    qcmr_checker #(
        .SUM_WIDTH(SUM_WIDTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_act_code      (i_act_code),
        .i_wt_code       (i_wt_code),
        .i_wt_zero_point (i_wt_zero_point),
        .i_in_window     (i_in_window),
        .i_bias_value    (i_bias_value),
        .i_scale_mantissa(i_scale_mantissa),
        .i_scale_shift   (i_scale_shift),
        .i_last_term     (i_last_term),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_result_code   (o_result_code),
        .i_overflow_flag (o_overflow_flag),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results),
        .o_result_count  (result_count),
        .o_overflow_count(overflow_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output stall source. A hold-off request keeps the output blocked long
    // enough for the block to fill up and stall its input.
    initial begin : output_stall
        int hold_seen;
        hold_seen = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_MAX);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_term_word make_word(input int act, input int wt, input int wzp,
                                             input bit win, input longint bias,
                                             input longint mant, input int sh,
                                             input bit last);
        t_term_word w;
        w.act   = CODE_W'(act);
        w.wt    = CODE_W'(wt);
        w.wzp   = CODE_W'(wzp);
        w.win   = win;
        w.bias  = BIAS_W'(bias);
        w.mant  = MANT_W'(mant);
        w.shift = SHIFT_W'(sh);
        w.last  = last;
        return w;
    endfunction

    // Mostly near the zero point so that sums stay small, otherwise any pattern.
    function automatic logic signed [CODE_W-1:0] pick_code(
        input logic signed [CODE_W-1:0] center);
        if ($urandom_range(0, 99) < 60) begin
            return CODE_W'(int'(center) + int'($urandom_range(0, 80)) - 40);
        end
        return CODE_W'($urandom_range(0, 511));
    endfunction

    function automatic logic signed [BIAS_W-1:0] pick_bias();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return BIAS_W'(int'($urandom_range(0, 8192)) - 4096);
            4, 5:       return '0;
            6:          return BIAS_W'($urandom);
            7:          return BIAS_W'(64'sd2147483647 - longint'($urandom_range(0, 300000)));
            8:          return BIAS_W'(-64'sd2147483648 + longint'($urandom_range(0, 300000)));
            default:    return BIAS_W'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic logic [MANT_W-1:0] pick_mant();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return '0;
        end
        if (pick < 20) begin
            return MANT_W'(MANT_MAX);
        end
        return MANT_W'($urandom);
    endfunction

    function automatic logic [SHIFT_W-1:0] pick_shift();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return SHIFT_W'($urandom_range(8, 18));
        end
        if (pick < 85) begin
            return SHIFT_W'($urandom_range(0, 31));
        end
        return SHIFT_W'($urandom_range(32, 63));
    endfunction

    // Offers one term word and returns at the edge that accepts it, leaving
    // i_valid high so back-to-back words need no extra assignment.
    task automatic offer_word(input t_term_word w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_act_code       <= w.act;
        i_wt_code        <= w.wt;
        i_wt_zero_point  <= w.wzp;
        i_in_window      <= w.win;
        i_bias_value     <= w.bias;
        i_scale_mantissa <= w.mant;
        i_scale_shift    <= w.shift;
        i_last_term      <= w.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // One output element: a run of taps of one channel, the final one marked last.
    task automatic send_element();
        int                       n_terms;
        int                       pick;
        logic signed [CODE_W-1:0] chan_zp;
        t_term_word               w;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            n_terms = $urandom_range(1, 6);
        end else if (pick < 95) begin
            n_terms = $urandom_range(7, 30);
        end else begin
            n_terms = $urandom_range(31, 60);
        end
        chan_zp = CODE_W'($urandom_range(0, 511));
        for (int t = 0; t < n_terms; t++) begin
            w.act   = pick_code(cur_in_zp);
            w.wzp   = ($urandom_range(0, 99) < 10) ? CODE_W'($urandom_range(0, 511)) : chan_zp;
            w.wt    = pick_code(w.wzp);
            w.win   = ($urandom_range(0, 99) >= 15);
            w.bias  = pick_bias();
            w.mant  = pick_mant();
            w.shift = pick_shift();
            w.last  = (t == n_terms - 1);
            offer_word(w);
        end
    endtask

    initial begin : stimulus
        t_term_word            directed_words[$];
        int                    phase_end;
        logic [CFG_DATA_W-1:0] new_izp;
        logic [CFG_DATA_W-1:0] new_ozp;
        logic                  new_sgn;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_act_code       <= '0;
        i_wt_code        <= '0;
        i_wt_zero_point  <= '0;
        i_in_window      <= 1'b0;
        i_bias_value     <= '0;
        i_scale_mantissa <= '0;
        i_scale_shift    <= '0;
        i_last_term      <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_IN_ZP;
        i_cfg_data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings: code extremes, padding on
        // the last term, zero mantissa, shifts past the product width, both
        // overflow directions, the int32 edge and round-half-to-even ties.
        directed_words.push_back(make_word(255, 255, -128, 1, 0, MANT_MAX, 0, 1));
        directed_words.push_back(make_word(-256, 255, -256, 1, 0, MANT_HALF, 10, 1));
        directed_words.push_back(make_word(-256, -256, 255, 1, 1000, MANT_MAX, 18, 1));
        directed_words.push_back(make_word(3, 5, 0, 1, 123, 5, 2, 0));
        directed_words.push_back(make_word(255, 255, 0, 0, 100, MANT_HALF, 0, 1));
        directed_words.push_back(make_word(100, 100, 0, 1, 0, 0, 0, 1));
        directed_words.push_back(make_word(1, 1, 0, 0, 64'sd2147483647, MANT_MAX, 31, 1));
        directed_words.push_back(make_word(7, 9, 0, 1, -5000, MANT_MAX, 32, 1));
        directed_words.push_back(make_word(7, 9, 0, 1, 5000, MANT_MAX, 33, 1));
        directed_words.push_back(make_word(7, 9, 0, 1, 5000, MANT_MAX, 63, 1));
        directed_words.push_back(make_word(1, 1, 0, 1, 64'sd2147483647, MANT_MAX, 0, 1));
        directed_words.push_back(make_word(1, 0, 1, 1, -64'sd2147483648, MANT_MAX, 0, 1));
        directed_words.push_back(make_word(0, 0, 0, 0, -64'sd2147483648, MANT_MAX, 0, 1));
        directed_words.push_back(make_word(0, 0, 0, 0, 64'sd2147483647, MANT_HALF, 24, 1));
        directed_words.push_back(make_word(0, 0, 0, 0, 1, MANT_HALF, 0, 1));
        directed_words.push_back(make_word(0, 0, 0, 0, 3, MANT_HALF, 0, 1));
        directed_words.push_back(make_word(0, 0, 0, 0, 5, MANT_HALF, 0, 1));
        directed_words.push_back(make_word(0, 0, 0, 0, -3, MANT_HALF, 0, 1));
        directed_words.push_back(make_word(0, 0, 0, 0, 511, MANT_HALF, 0, 1));
        foreach (directed_words[k]) begin
            offer_word(directed_words[k]);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Registers change only once the block has drained.
            i_valid <= 1'b0;
            do @(posedge i_clk); while (pending_results != 0);
            repeat (QUIET_CYCLES) @(posedge i_clk);
            case (phase)
                0: begin
                    new_izp = CFG_DATA_W'(-128);
                    new_ozp = CFG_DATA_W'(255);
                    new_sgn = 1'b1;
                end
                1: begin
                    new_izp = CFG_DATA_W'(255);
                    new_ozp = CFG_DATA_W'(-128);
                    new_sgn = 1'b0;
                end
                2: begin
                    new_izp = CFG_DATA_W'(-256);
                    new_ozp = CFG_DATA_W'(-256);
                    new_sgn = 1'b1;
                end
                3: begin
                    new_izp = '0;
                    new_ozp = '0;
                    new_sgn = 1'b0;
                end
                default: begin
                    new_izp = CFG_DATA_W'($urandom_range(0, 511));
                    new_ozp = CFG_DATA_W'($urandom_range(0, 511));
                    new_sgn = 1'($urandom_range(0, 1));
                end
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IN_ZP;
            i_cfg_data <= new_izp;
            @(posedge i_clk);
            i_cfg_idx  <= CFG_OUT_ZP;
            i_cfg_data <= new_ozp;
            @(posedge i_clk);
            i_cfg_idx  <= CFG_OUT_SIGNED;
            i_cfg_data <= {8'($urandom), new_sgn};
            @(posedge i_clk);
            // A write to the spare index must leave every register alone.
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= CFG_DATA_W'($urandom);
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            cur_in_zp = signed'(new_izp);

            case (phase % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 73;
                end
                default: begin
                    tx_idle_pct = 8;
                    rx_stall_pct <= 8;
                end
            endcase
            if (phase == 0) begin
                hold_ask <= hold_ask + 1;
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                send_element();
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d term words and %0d result words (%0d overflowed)",
                 words_sent, result_count, overflow_count);
        $display("over %0d settings, with free flow, sender gaps, output stalls, both,",
                 NUM_PHASES + 1);
        $display("and one long output hold-off.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/qcmr_pkg.sv
design/qcmr_front.sv
design/qcmr_queue.sv
design/qcmr_back.sv
design/quantized_conv_mac_requantize_top.sv
sim/qcmr_checker.sv
sim/tb_quantized_conv_mac_requantize_top.sv
